// ===== hw/rtl/rgb_ycbcr_color_convert_unit_assert.svh =====
// ----------------------------------------------------------------------------
// RGB/YCbCr converter assertion macros
// Shared property wrappers, clocked on clk and quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef RGB_YCBCR_COLOR_CONVERT_UNIT_ASSERT_SVH
`define RGB_YCBCR_COLOR_CONVERT_UNIT_ASSERT_SVH

// Check cons whenever ante holds; cons may itself be a sequence with a delay.
`define RYCC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error(msg);

// Check cons in the cycle after ante holds.
`define RYCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rycc_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB/YCbCr converter package
// Fixed-point formats, studio limits, reciprocals and the matrix table.
// ----------------------------------------------------------------------------
package rycc_pkg;

  // Sample and coefficient formats
  localparam int FRAC_BITS      = 15;
  localparam int COEF_FRAC_BITS = 16;
  localparam int FIELD_W        = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PRIMARIES     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_STUDIO  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_STUDIO = CFG_IDX_W'(3);

  localparam logic DIR_TO_YCBCR = 1'b0;
  localparam logic DIR_TO_RGB   = 1'b1;

  localparam logic [1:0] PRI_BT709  = 2'd0;
  localparam logic [1:0] PRI_BT2020 = 2'd1;
  localparam logic [1:0] PRI_BT601  = 2'd2;

  // Lane numbering: lane A is R or Y, lanes B and C carry G/Cb and B/Cr
  localparam int LANE_IDX_W = 2;
  typedef logic [LANE_IDX_W-1:0] lane_idx_t;
  localparam lane_idx_t LANE_A = LANE_IDX_W'(0);

  // Internal widths
  localparam int SAMPLE_W    = (FRAC_BITS + 1 > FIELD_W) ? FRAC_BITS + 1 : FIELD_W;
  localparam int RES_W       = FRAC_BITS + 1;
  localparam int RANGE_W     = FRAC_BITS;
  localparam int NUM_W       = 2 * FRAC_BITS + 1;
  localparam int RECIP_SHIFT = 2 * FRAC_BITS + 15;
  localparam int RECIP_W     = FRAC_BITS + 16;
  localparam int QEST_W      = FRAC_BITS + 1;
  localparam int EXP_PROD_W  = NUM_W + RECIP_W;
  localparam int COEF_W      = COEF_FRAC_BITS + 2;
  localparam int XS_W        = SAMPLE_W + 2;
  localparam int MAT_PROD_W  = XS_W + COEF_W;
  localparam int ACC_W       = MAT_PROD_W + 2;
  localparam int T_W         = ACC_W - COEF_FRAC_BITS;
  localparam int SCALE_W     = RES_W + RANGE_W + 1;
  localparam int ZSUM_W      = SCALE_W - FRAC_BITS + 1;

  // Studio limits, rounded half up from thousandths
  localparam longint ONE_Q     = longint'(1) << FRAC_BITS;
  localparam longint HALF_Q    = ONE_Q >> 1;
  localparam longint LO_Q      = ((longint'(63) << FRAC_BITS) + 500) / 1000;
  localparam longint HI_Y_Q    = ((longint'(920) << FRAC_BITS) + 500) / 1000;
  localparam longint HI_C_Q    = ((longint'(940) << FRAC_BITS) + 500) / 1000;
  localparam longint RANGE_Y_Q = HI_Y_Q - LO_Q;
  localparam longint RANGE_C_Q = HI_C_Q - LO_Q;

  localparam logic [SAMPLE_W-1:0] ONE  = SAMPLE_W'(ONE_Q);
  localparam logic [SAMPLE_W-1:0] HALF = SAMPLE_W'(HALF_Q);
  localparam logic [SAMPLE_W-1:0] LO   = SAMPLE_W'(LO_Q);
  localparam logic [SAMPLE_W-1:0] HI_Y = SAMPLE_W'(HI_Y_Q);
  localparam logic [SAMPLE_W-1:0] HI_C = SAMPLE_W'(HI_C_Q);

  localparam logic [RANGE_W-1:0] RANGE_Y = RANGE_W'(RANGE_Y_Q);
  localparam logic [RANGE_W-1:0] RANGE_C = RANGE_W'(RANGE_C_Q);

  // Truncated reciprocals; the quotient estimate is low by at most one
  localparam logic [RECIP_W-1:0] RECIP_Y =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(RANGE_Y_Q));
  localparam logic [RECIP_W-1:0] RECIP_C =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(RANGE_C_Q));

  // Chroma offset after the matrix, and the rounding constant
  localparam logic signed [ACC_W-1:0] OFFSET = ACC_W'(HALF_Q << COEF_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'(longint'(1) << (COEF_FRAC_BITS - 1));

  // Pipeline depths
  localparam int EXP_LAT    = 3;
  localparam int MAT_LAT    = 3;
  localparam int PIPE_DEPTH = EXP_LAT + MAT_LAT + 1;

  // Matrix in millionths: [direction][primaries][row][col], flattened
  localparam int N_COEF     = 54;
  localparam int COEF_IDX_W = $clog2(N_COEF);

  localparam int MAT_MICRO [N_COEF] = '{
    // to YCbCr, BT.709
    212600, 715200, 72200, -114572, -385428, 500000, 500000, -454153, -45847,
    // to YCbCr, BT.2020
    262700, 678000, 59300, -139630, -360370, 500000, 500000, -459786, -40214,
    // to YCbCr, BT.601
    299000, 587000, 114000, -168736, -331264, 500000, 500000, -418688, -81312,
    // to RGB, BT.709
    1000000, 0, 1574800, 1000000, -187324, -468124, 1000000, 1855600, 0,
    // to RGB, BT.2020
    1000000, 0, 1474600, 1000000, -164553, -571353, 1000000, 1881400, 0,
    // to RGB, BT.601
    1000000, 0, 1402000, 1000000, -344136, -714136, 1000000, 1772000, 0
  };

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t coef_tab_t [N_COEF];

  // Round half away from zero into signed Q.COEF_FRAC_BITS
  function automatic coef_tab_t build_coef_tab();
    coef_tab_t tab;
    longint    m;
    longint    q;
    for (int k = 0; k < N_COEF; k++) begin
      m = (MAT_MICRO[k] < 0) ? -longint'(MAT_MICRO[k]) : longint'(MAT_MICRO[k]);
      q = ((m << COEF_FRAC_BITS) + 500000) / 1000000;
      tab[k] = COEF_W'((MAT_MICRO[k] < 0) ? -q : q);
    end
    return tab;
  endfunction

  localparam coef_tab_t COEF_TAB = build_coef_tab();

  function automatic logic [COEF_IDX_W-1:0] coef_idx(input logic dir, input logic [1:0] pri,
                                                     input lane_idx_t row, input lane_idx_t col);
    return COEF_IDX_W'(((int'(dir) * 3 + int'(pri)) * 3 + int'(row)) * 3 + int'(col));
  endfunction

  // Live configuration as the lanes see it
  typedef struct packed {
    logic       direction;
    logic [1:0] primaries;
    logic       input_studio;
    logic       output_studio;
  } rycc_cfg_t;

endpackage

// ===== hw/rtl/rycc_expand_lane.sv =====
// ----------------------------------------------------------------------------
// RGB/YCbCr converter studio expansion lane
// Expands one studio-range component to full range (passes it through when input is full range), three pipeline stages.
// ----------------------------------------------------------------------------
module rycc_expand_lane (
  input  logic                           clk,
  input  rycc_pkg::rycc_cfg_t            cfg,
  input  rycc_pkg::lane_idx_t            lane,
  input  logic [rycc_pkg::FIELD_W-1:0]   x_in,
  output logic [rycc_pkg::SAMPLE_W-1:0]  x_out
);
  import rycc_pkg::*;

  logic                  chroma_in;
  logic [RANGE_W-1:0]    rng;
  logic [RECIP_W-1:0]    recip;
  logic [SAMPLE_W-1:0]   x_ext;
  logic [SAMPLE_W-1:0]   diff;
  logic [NUM_W-1:0]      num;

  logic [SAMPLE_W-1:0]   s1_raw;
  logic                  s1_low;
  logic                  s1_sat;
  logic                  s1_studio;
  logic [NUM_W-1:0]      s1_num;
  logic [RANGE_W-1:0]    s1_rng;
  logic [RECIP_W-1:0]    s1_recip;

  logic [EXP_PROD_W-1:0] prod;
  logic [QEST_W-1:0]     s2_qest;
  logic [SAMPLE_W-1:0]   s2_raw;
  logic                  s2_low;
  logic                  s2_sat;
  logic                  s2_studio;
  logic [NUM_W-1:0]      s2_num;
  logic [RANGE_W-1:0]    s2_rng;

  logic [NUM_W-1:0]      qr;
  logic [NUM_W-1:0]      rem;
  logic [QEST_W-1:0]     q;

  // Numerator (x - lo) * ONE + range / 2; only used when x - lo < range
  always_comb begin
    chroma_in = (lane != LANE_A) && (cfg.direction == DIR_TO_RGB);
    rng       = chroma_in ? RANGE_C : RANGE_Y;
    recip     = chroma_in ? RECIP_C : RECIP_Y;
    x_ext     = SAMPLE_W'(x_in);
    diff      = x_ext - LO;
    num       = NUM_W'({diff[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}}) + NUM_W'(rng >> 1);
  end

  always_ff @(posedge clk) begin
    s1_raw    <= x_ext;
    s1_low    <= (x_ext <= LO);
    s1_sat    <= (diff >= SAMPLE_W'(rng));
    s1_studio <= cfg.input_studio;
    s1_num    <= num;
    s1_rng    <= rng;
    s1_recip  <= recip;
  end

  // Quotient estimate by reciprocal
  assign prod = EXP_PROD_W'(s1_num) * EXP_PROD_W'(s1_recip);

  always_ff @(posedge clk) begin
    s2_qest   <= prod[RECIP_SHIFT +: QEST_W];
    s2_raw    <= s1_raw;
    s2_low    <= s1_low;
    s2_sat    <= s1_sat;
    s2_studio <= s1_studio;
    s2_num    <= s1_num;
    s2_rng    <= s1_rng;
  end

  // Bump the estimate when the remainder still holds a full range
  always_comb begin
    qr  = NUM_W'(s2_qest) * NUM_W'(s2_rng);
    rem = s2_num - qr;
    q   = s2_qest + QEST_W'(rem >= NUM_W'(s2_rng));
  end

  always_ff @(posedge clk) begin
    if (!s2_studio) begin
      x_out <= s2_raw;
    end else if (s2_low) begin
      x_out <= '0;
    end else if (s2_sat) begin
      x_out <= ONE;
    end else begin
      x_out <= SAMPLE_W'(q);
    end
  end

endmodule

// ===== hw/rtl/rycc_matrix_lane.sv =====
// ----------------------------------------------------------------------------
// RGB/YCbCr converter matrix lane
// One matrix row: products, sum with rounding and clip, and studio compression when the output is studio range.
// ----------------------------------------------------------------------------
module rycc_matrix_lane (
  input  logic                           clk,
  input  rycc_pkg::rycc_cfg_t            cfg,
  input  rycc_pkg::lane_idx_t            lane,
  input  logic [rycc_pkg::SAMPLE_W-1:0]  x0,
  input  logic [rycc_pkg::SAMPLE_W-1:0]  x1,
  input  logic [rycc_pkg::SAMPLE_W-1:0]  x2,
  output logic [rycc_pkg::FIELD_W-1:0]   y
);
  import rycc_pkg::*;

  logic [SAMPLE_W-1:0]          xv [3];
  logic signed [XS_W-1:0]       xs [3];
  coef_t                        cf [3];
  logic                         chroma_out;

  logic signed [MAT_PROD_W-1:0] s1_prod [3];
  logic                         s1_chroma;
  logic                         s1_ostudio;

  logic signed [ACC_W-1:0]      acc;
  logic signed [ACC_W-1:0]      rnd;
  logic [T_W-1:0]               t;
  logic [RES_W-1:0]             r;

  logic [RES_W-1:0]             s2_r;
  logic                         s2_chroma;
  logic                         s2_ostudio;

  logic [RANGE_W-1:0]           rng_out;
  logic [SAMPLE_W-1:0]          hi;
  logic [SCALE_W-1:0]           scaled;
  logic [ZSUM_W-1:0]            zsum;
  logic [SAMPLE_W-1:0]          z;

  // Take chroma offset off before the matrix toward RGB
  always_comb begin
    xv[0]      = x0;
    xv[1]      = x1;
    xv[2]      = x2;
    chroma_out = (lane != LANE_A) && (cfg.direction == DIR_TO_YCBCR);
    for (int col = 0; col < 3; col++) begin
      xs[col] = $signed(XS_W'(xv[col]));
      if ((cfg.direction == DIR_TO_RGB) && (col != 0)) begin
        xs[col] = xs[col] - $signed(XS_W'(HALF));
      end
      cf[col] = COEF_TAB[coef_idx(cfg.direction, cfg.primaries, lane, LANE_IDX_W'(col))];
    end
  end

  always_ff @(posedge clk) begin
    for (int col = 0; col < 3; col++) begin
      s1_prod[col] <= MAT_PROD_W'(xs[col]) * MAT_PROD_W'(cf[col]);
    end
    s1_chroma  <= chroma_out;
    s1_ostudio <= cfg.output_studio;
  end

  // Sum, add chroma offset, round half up, clip to 0..ONE
  always_comb begin
    acc = ACC_W'(s1_prod[0]) + ACC_W'(s1_prod[1]) + ACC_W'(s1_prod[2])
        + (s1_chroma ? OFFSET : ACC_W'(0));
    rnd = acc + ROUND;
    t   = rnd[ACC_W-1:COEF_FRAC_BITS];
    if (acc[ACC_W-1] || (acc == ACC_W'(0))) begin
      r = '0;
    end else if (t > T_W'(ONE)) begin
      r = RES_W'(ONE);
    end else begin
      r = RES_W'(t);
    end
  end

  always_ff @(posedge clk) begin
    s2_r       <= r;
    s2_chroma  <= s1_chroma;
    s2_ostudio <= s1_ostudio;
  end

  // Compress into studio limits
  always_comb begin
    rng_out = s2_chroma ? RANGE_C : RANGE_Y;
    hi      = s2_chroma ? HI_C : HI_Y;
    scaled  = SCALE_W'(s2_r) * SCALE_W'(rng_out) + SCALE_W'(HALF);
    zsum    = ZSUM_W'(scaled >> FRAC_BITS) + ZSUM_W'(LO);
    if (zsum < ZSUM_W'(LO)) begin
      z = LO;
    end else if (zsum > ZSUM_W'(hi)) begin
      z = hi;
    end else begin
      z = SAMPLE_W'(zsum);
    end
  end

  always_ff @(posedge clk) begin
    y <= s2_ostudio ? FIELD_W'(z) : FIELD_W'(s2_r);
  end

endmodule

// ===== hw/rtl/rgb_ycbcr_color_convert_unit.sv =====
// ----------------------------------------------------------------------------
// RGB/YCbCr color conversion unit
// One pixel per clock while busy is low, between RGB and YCbCr, BT.709, BT.2020 or BT.601.
// ----------------------------------------------------------------------------
// A pixel word is taken on every clock edge where start is high and busy is
// low, so a new pixel may follow in every cycle. Each result appears on
// out_a, out_b, out_c and alpha_out for exactly one cycle with done high, in
// start order; the receiver cannot hold it off, so capture it on that cycle.
// The pipeline holds three stages of studio expansion (reciprocal multiply,
// remainder check), three stages per matrix row (products, rounded sum, studio
// compression) and the output merge register. busy is high during reset and
// for the first cycle after it. Write the configuration registers only while
// no pixel is in flight; they feed the first stage of every expansion lane
// and matrix row directly.
`include "rgb_ycbcr_color_convert_unit_assert.svh"

module rgb_ycbcr_color_convert_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  output logic                             done,
  input  logic                             wr_en,
  input  logic [rycc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [rycc_pkg::CFG_DATA_W-1:0]  wr_data,
  input  logic [rycc_pkg::FIELD_W-1:0]     comp_a,
  input  logic [rycc_pkg::FIELD_W-1:0]     comp_b,
  input  logic [rycc_pkg::FIELD_W-1:0]     comp_c,
  input  logic [rycc_pkg::FIELD_W-1:0]     alpha_in,
  output logic [rycc_pkg::FIELD_W-1:0]     out_a,
  output logic [rycc_pkg::FIELD_W-1:0]     out_b,
  output logic [rycc_pkg::FIELD_W-1:0]     out_c,
  output logic [rycc_pkg::FIELD_W-1:0]     alpha_out
);
  import rycc_pkg::*;

  // Configuration registers
  logic                  direction;
  logic [1:0]            primaries;
  logic                  input_studio;
  logic                  output_studio;
  rycc_cfg_t             cfg;

  logic                  accept;
  logic [PIPE_DEPTH-1:0] vld;
  logic [FIELD_W-1:0]    alpha_dly [PIPE_DEPTH-1];

  logic [FIELD_W-1:0]    comp_in [3];
  logic [SAMPLE_W-1:0]   x_exp [3];
  logic [FIELD_W-1:0]    y [3];

  assign accept = start && !busy;

  // Register writes; unused code bits drop
  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= DIR_TO_YCBCR;
      primaries     <= PRI_BT709;
      input_studio  <= 1'b0;
      output_studio <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_DIRECTION:     direction     <= wr_data[0];
        REG_PRIMARIES:     primaries     <= wr_data;
        REG_INPUT_STUDIO:  input_studio  <= wr_data[0];
        REG_OUTPUT_STUDIO: output_studio <= wr_data[0];
        default: ;
      endcase
    end
  end

  // The spare primaries code selects BT.601
  always_comb begin
    cfg.direction     = direction;
    cfg.primaries     = (primaries > PRI_BT601) ? PRI_BT601 : primaries;
    cfg.input_studio  = input_studio;
    cfg.output_studio = output_studio;
  end

  // Hold busy for one cycle out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Advance the word valid flags alongside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], accept};
    end
  end

  assign done = vld[PIPE_DEPTH-1];

  // Alpha rides a plain delay line
  always_ff @(posedge clk) begin
    alpha_dly[0] <= alpha_in;
    for (int k = 1; k < PIPE_DEPTH - 1; k++) begin
      alpha_dly[k] <= alpha_dly[k-1];
    end
  end

  assign comp_in[0] = comp_a;
  assign comp_in[1] = comp_b;
  assign comp_in[2] = comp_c;

  // One expansion lane and one matrix row per component
  for (genvar g = 0; g < 3; g++) begin : g_lane
    rycc_expand_lane u_expand (
      .clk   (clk),
      .cfg   (cfg),
      .lane  (LANE_IDX_W'(g)),
      .x_in  (comp_in[g]),
      .x_out (x_exp[g])
    );

    rycc_matrix_lane u_matrix (
      .clk  (clk),
      .cfg  (cfg),
      .lane (LANE_IDX_W'(g)),
      .x0   (x_exp[0]),
      .x1   (x_exp[1]),
      .x2   (x_exp[2]),
      .y    (y[g])
    );
  end

  // Merge the three rows and alpha into the output word
  always_ff @(posedge clk) begin
    if (vld[PIPE_DEPTH-2]) begin
      out_a     <= y[0];
      out_b     <= y[1];
      out_c     <= y[2];
      alpha_out <= alpha_dly[PIPE_DEPTH-2];
    end
  end

  `RYCC_ASSERT_IMP(a_latency, accept, ##PIPE_DEPTH done, "result word missing at latency")
  `RYCC_ASSERT_IMP(a_no_orphan, done, $past(accept, PIPE_DEPTH), "result word without a start")
  `RYCC_ASSERT_IMP(a_alpha, done, alpha_out == $past(alpha_in, PIPE_DEPTH), "alpha not carried")
  `RYCC_ASSERT_IMP(a_studio_y, done && output_studio, out_a >= LO && out_a <= HI_Y, "studio out_a out of limits")
  `RYCC_ASSERT_NEXT(a_busy_short, busy, !busy, "busy held past reset")

endmodule

// ===== bench/rgb_ycbcr_color_convert_unit_tb.sv =====
// ----------------------------------------------------------------------------
// RGB/YCbCr color conversion unit testbench
// Streams pixel words through every direction, primaries code and range flag
// setting. Each result is checked against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_ycbcr_color_convert_unit_tb;
  import rycc_pkg::*;

  // One pixel word: lanes 0..2 are the color components, lane 3 is alpha
  typedef logic [3:0][FIELD_W-1:0] pixel_t;

  localparam int     RANDOM_PER_SETTING = 48;
  localparam int     DRAIN_CYCLES       = 12;
  localparam longint CYCLE_LIMIT        = 400000;

  // Studio limits and unity in Q.FRAC_BITS, rounded half up from thousandths
  localparam longint UNIT      = longint'(1) << FRAC_BITS;
  localparam longint HALF_UNIT = UNIT >> 1;
  localparam longint LIM_LO    = ((longint'(63) << FRAC_BITS) + 500) / 1000;
  localparam longint LIM_HI_Y  = ((longint'(920) << FRAC_BITS) + 500) / 1000;
  localparam longint LIM_HI_C  = ((longint'(940) << FRAC_BITS) + 500) / 1000;

  // Conversion matrices in millionths: [to RGB][primaries][row][col] flattened
  localparam int MATRIX_MICRO [54] = '{
    212600, 715200, 72200, -114572, -385428, 500000, 500000, -454153, -45847,
    262700, 678000, 59300, -139630, -360370, 500000, 500000, -459786, -40214,
    299000, 587000, 114000, -168736, -331264, 500000, 500000, -418688, -81312,
    1000000, 0, 1574800, 1000000, -187324, -468124, 1000000, 1855600, 0,
    1000000, 0, 1474600, 1000000, -164553, -571353, 1000000, 1881400, 0,
    1000000, 0, 1402000, 1000000, -344136, -714136, 1000000, 1772000, 0
  };

  // --------------------------------------------------------------------------
  // Color checker: holds the live register copy, predicts each pixel and
  // matches converted words against the oldest prediction
  // --------------------------------------------------------------------------
  class color_checker;
    bit          to_rgb;
    bit [1:0]    pri_code;
    bit          in_studio;
    bit          out_studio;
    longint      coef_q [54];
    pixel_t      awaited_pixels [$];
    int unsigned mismatches;
    int unsigned pixels_taken;
    int unsigned results_seen;

    function new();
      longint mag;
      for (int k = 0; k < 54; k++) begin
        mag = (MATRIX_MICRO[k] < 0) ? -longint'(MATRIX_MICRO[k]) : longint'(MATRIX_MICRO[k]);
        mag = ((mag << COEF_FRAC_BITS) + 500000) / 1000000;
        coef_q[k] = (MATRIX_MICRO[k] < 0) ? -mag : mag;
      end
    endfunction

    // Keep only the low bits a register holds
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DIRECTION:     to_rgb     = val[0];
        REG_PRIMARIES:     pri_code   = val[1:0];
        REG_INPUT_STUDIO:  in_studio  = val[0];
        REG_OUTPUT_STUDIO: out_studio = val[0];
        default: ;
      endcase
    endfunction

    function longint stretch(longint v, longint hi);
      longint span;
      longint y;
      span = hi - LIM_LO;
      if (v <= LIM_LO) return 0;
      y = (((v - LIM_LO) << FRAC_BITS) + (span >> 1)) / span;
      return (y > UNIT) ? UNIT : y;
    endfunction

    function longint squeeze(longint r, longint hi);
      longint z;
      z = ((r * (hi - LIM_LO) + (UNIT >> 1)) >> FRAC_BITS) + LIM_LO;
      if (z < LIM_LO) z = LIM_LO;
      if (z > hi) z = hi;
      return z;
    endfunction

    function pixel_t convert_pixel(pixel_t p);
      pixel_t res;
      longint xs [3];
      longint acc;
      longint r;
      longint hi;
      int     pri;
      int     base;
      pri  = (pri_code > 2) ? 2 : int'(pri_code);
      base = (int'(to_rgb) * 3 + pri) * 9;
      for (int i = 0; i < 3; i++) begin
        xs[i] = longint'(p[i]);
        if (in_studio) begin
          // chroma limits apply on the input side only for YCbCr input
          hi = (i == 0 || to_rgb == DIR_TO_YCBCR) ? LIM_HI_Y : LIM_HI_C;
          xs[i] = stretch(xs[i], hi);
        end
      end
      if (to_rgb == DIR_TO_RGB) begin
        xs[1] -= HALF_UNIT;
        xs[2] -= HALF_UNIT;
      end
      for (int row = 0; row < 3; row++) begin
        acc = 0;
        for (int col = 0; col < 3; col++)
          acc += coef_q[base + row * 3 + col] * xs[col];
        if (to_rgb == DIR_TO_YCBCR && row > 0)
          acc += HALF_UNIT << COEF_FRAC_BITS;
        if (acc <= 0) begin
          r = 0;
        end else begin
          r = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
          if (r > UNIT) r = UNIT;
        end
        if (out_studio) begin
          hi = (row == 0 || to_rgb == DIR_TO_RGB) ? LIM_HI_Y : LIM_HI_C;
          r = squeeze(r, hi);
        end
        res[row] = r[FIELD_W-1:0];
      end
      res[3] = p[3];
      return res;
    endfunction

    function void note_pixel(pixel_t p);
      awaited_pixels.push_back(convert_pixel(p));
      pixels_taken++;
    endfunction

    function void check_result(pixel_t got);
      pixel_t want;
      string  lane_name [4];
      lane_name = '{"out_a", "out_b", "out_c", "alpha_out"};
      results_seen++;
      if (awaited_pixels.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        mismatches++;
        return;
      end
      want = awaited_pixels.pop_front();
      for (int k = 0; k < 4; k++) begin
        if (got[k] !== want[k]) begin
          $display("%0t: %s mismatch, expected %0d, actual %0d",
                   $time, lane_name[k], want[k], got[k]);
          mismatches++;
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block hookup
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  done;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;
  logic [FIELD_W-1:0]    comp_a;
  logic [FIELD_W-1:0]    comp_b;
  logic [FIELD_W-1:0]    comp_c;
  logic [FIELD_W-1:0]    alpha_in;
  logic [FIELD_W-1:0]    out_a;
  logic [FIELD_W-1:0]    out_b;
  logic [FIELD_W-1:0]    out_c;
  logic [FIELD_W-1:0]    alpha_out;

  rgb_ycbcr_color_convert_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .comp_a    (comp_a),
    .comp_b    (comp_b),
    .comp_c    (comp_c),
    .alpha_in  (alpha_in),
    .out_a     (out_a),
    .out_b     (out_b),
    .out_c     (out_c),
    .alpha_out (alpha_out)
  );

  color_checker checker_h;
  int           sender_idle_pct;
  int           settings_run;
  longint       cycle_count;

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: stop a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("Some tests failed");
    $finish;
  end

  // Monitor: sample the pre-edge values, so the handshake seen here is the one
  // the block acts on at this edge. A word is taken when start is high and busy
  // low; a converted word is valid for the single cycle that done is high.
  always @(posedge clk) begin
    if (!rst) begin
      if (wr_en) checker_h.write_reg(wr_index, wr_data);
      if (start && !busy) checker_h.note_pixel({alpha_in, comp_c, comp_b, comp_a});
      if (done) checker_h.check_result({alpha_out, out_c, out_b, out_a});
    end
  end

  function automatic pixel_t pix(longint a, longint b, longint c, longint al);
    pixel_t p;
    p[0] = a[FIELD_W-1:0];
    p[1] = b[FIELD_W-1:0];
    p[2] = c[FIELD_W-1:0];
    p[3] = al[FIELD_W-1:0];
    return p;
  endfunction

  // Sample mix: mostly in range, some right at the studio limits and unity,
  // some with any 16-bit pattern to cover over-range inputs
  function automatic logic [FIELD_W-1:0] pick_sample();
    longint anchors [6];
    longint v;
    anchors = '{0, LIM_LO, LIM_HI_Y, LIM_HI_C, HALF_UNIT, UNIT};
    case ($urandom_range(9))
      0, 1: v = $urandom_range(16'hFFFF);
      2, 3: begin
        v = anchors[$urandom_range(5)] + $urandom_range(8) - 4;
        if (v < 0) v = 0;
      end
      default: v = $urandom_range(UNIT);
    endcase
    return v[FIELD_W-1:0];
  endfunction

  // Present one word and hold it until the block takes it; each cycle idles
  // first with the set chance
  task automatic send_pixel(pixel_t p);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    comp_a   <= p[0];
    comp_b   <= p[1];
    comp_c   <= p[2];
    alpha_in <= p[3];
    do @(posedge clk); while (busy);
  endtask

  // Drop start, let the monitor note the last word, then wait for every
  // predicted word to come out
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (checker_h.awaited_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
  endtask

  // Write all four registers; one-bit registers get a random junk upper bit
  task automatic set_config(bit dir, bit [1:0] pri, bit si, bit so);
    put_reg(REG_DIRECTION, {1'($urandom_range(1)), dir});
    put_reg(REG_PRIMARIES, pri);
    put_reg(REG_INPUT_STUDIO, {1'($urandom_range(1)), si});
    put_reg(REG_OUTPUT_STUDIO, {1'($urandom_range(1)), so});
    wr_en <= 1'b0;
    settings_run++;
  endtask

  initial begin
    checker_h       = new();
    cycle_count     = 0;
    sender_idle_pct = 0;
    settings_run    = 0;
    rst      <= 1'b1;
    start    <= 1'b0;
    wr_en    <= 1'b0;
    wr_index <= '0;
    wr_data  <= '0;
    comp_a   <= '0;
    comp_b   <= '0;
    comp_c   <= '0;
    alpha_in <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: RGB to YCbCr, full range, field extremes and bit patterns
    set_config(DIR_TO_YCBCR, PRI_BT709, 1'b0, 1'b0);
    send_pixel(pix(0, 0, 0, 0));
    send_pixel(pix(UNIT, UNIT, UNIT, UNIT));
    send_pixel(pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pix(UNIT, 0, 0, 0));
    send_pixel(pix(0, UNIT, 0, 0));
    send_pixel(pix(0, 0, UNIT, 12345));
    send_pixel(pix(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
    send_pixel(pix(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    settle();

    // Directed: YCbCr to RGB, primaries code three, studio on both sides;
    // walk across the studio limits and push chroma to the negative corner
    set_config(DIR_TO_RGB, 2'd3, 1'b1, 1'b1);
    send_pixel(pix(LIM_LO - 1, HALF_UNIT, HALF_UNIT, 0));
    send_pixel(pix(LIM_LO, LIM_LO, LIM_LO, 1));
    send_pixel(pix(LIM_LO + 1, LIM_HI_C, LIM_HI_C, 2));
    send_pixel(pix(LIM_HI_Y, LIM_HI_C + 1, 0, 3));
    send_pixel(pix(LIM_HI_Y + 1, 0, UNIT, 4));
    send_pixel(pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pix(0, 0, 0, 0));
    send_pixel(pix(UNIT, HALF_UNIT, HALF_UNIT, UNIT));
    settle();

    // Directed: studio RGB in at its limits, full-range YCbCr out
    set_config(DIR_TO_YCBCR, PRI_BT2020, 1'b1, 1'b0);
    send_pixel(pix(LIM_HI_Y, LIM_HI_Y, LIM_HI_Y, 7));
    send_pixel(pix(LIM_LO, LIM_LO, LIM_LO, 8));
    send_pixel(pix(LIM_HI_C, LIM_LO, LIM_HI_C, 9));
    settle();

    // Directed: full-range YCbCr in, studio RGB out
    set_config(DIR_TO_RGB, PRI_BT601, 1'b0, 1'b1);
    send_pixel(pix(UNIT, 0, 16'hFFFF, 10));
    send_pixel(pix(0, HALF_UNIT, HALF_UNIT, 11));
    settle();

    // Random: every combination of direction, primaries code (three included)
    // and range flags. The first third gives the sender a ten percent idle chance,
    // the second forty-nine percent, the last none and streams back to back.
    for (int ph = 0; ph < 32; ph++) begin
      sender_idle_pct = (ph < 11) ? 10 : (ph < 22) ? 49 : 0;
      set_config(ph[0], ph[2:1], ph[3], ph[4]);
      for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
        pixel_t p;
        p[0] = pick_sample();
        p[1] = pick_sample();
        p[2] = pick_sample();
        p[3] = ($urandom_range(3) == 0) ? 16'($urandom_range(16'hFFFF))
                                        : 16'($urandom_range(UNIT));
        send_pixel(p);
      end
      settle();
    end

    // Let the pipeline run dry, then look for strays and leftovers
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (checker_h.awaited_pixels.size() != 0) begin
      $display("%0t: %0d predicted words never came out",
               $time, checker_h.awaited_pixels.size());
      checker_h.mismatches++;
    end

    $display("Converted %0d pixels over %0d register settings: both directions,",
             checker_h.pixels_taken, settings_run);
    $display("all four primaries codes, every range flag pair; %0d words checked.",
             checker_h.results_seen);
    if (checker_h.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rycc_pkg.sv
hw/rtl/rycc_expand_lane.sv
hw/rtl/rycc_matrix_lane.sv
hw/rtl/rgb_ycbcr_color_convert_unit.sv
bench/rgb_ycbcr_color_convert_unit_tb.sv
